@@ hw/rtl/rotating_gray4_frame_writer_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rotating gray4 frame writer core
// Clocked implication checks, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef ROTATING_GRAY4_FRAME_WRITER_CORE_ASSERT_SVH
`define ROTATING_GRAY4_FRAME_WRITER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RGFW_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgfw same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RGFW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgfw next-cycle check failed");

`endif

@@ hw/rtl/rgfw_pkg.sv @@
// ----------------------------------------------------------------------------
// rgfw_pkg
// Shared constants and types of the rotating gray4 frame writer.
// ----------------------------------------------------------------------------
package rgfw_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 768;
  localparam int STORE_BYTES = MAX_WIDTH * MAX_HEIGHT / 2;
  localparam int STORE_AW    = $clog2(STORE_BYTES);

  typedef enum logic [1:0] {
    OP_AREA    = 2'd0,
    OP_PIXEL   = 2'd1,
    OP_PRESENT = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_PANEL_WIDTH  = 2'd0,
    CFG_PANEL_HEIGHT = 2'd1,
    CFG_ROTATION     = 2'd2
  } cfg_idx_t;

  localparam logic KIND_PRESENT = 1'b0;
  localparam logic KIND_READ    = 1'b1;

endpackage

@@ hw/rtl/rgfw_ram.sv @@
// ----------------------------------------------------------------------------
// rgfw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rgfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/rotating_gray4_frame_writer_core.sv @@
// ----------------------------------------------------------------------------
// rotating_gray4_frame_writer_core: RGB565 to 4-bit gray frame writer with rotation
// Pipeline: a present or read result passes stages 1 and 2 into the output register.
// Throughput: one beat per cycle unless a waiting result stalls it, with a frame RAM read at stage 1 and the nibble
// write-back at stage 2, forwarded to the following read of the same byte.
// Reset: synchronous, active low; clears control state, then a clearing pass writes 0xFF
// to all 393216 bytes, one per cycle, with in_ready low; configuration is still taken.
// ----------------------------------------------------------------------------
module rotating_gray4_frame_writer_core
  import rgfw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [10:0] in_area_left,
  input  logic [10:0] in_area_top,
  input  logic [10:0] in_area_right,
  input  logic [10:0] in_area_bottom,
  input  logic [15:0] in_color,
  input  logic        in_full_refresh,
  input  logic [18:0] in_read_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic        out_rect_valid,
  output logic [9:0]  out_rect_x,
  output logic [9:0]  out_rect_y,
  output logic [10:0] out_rect_w,
  output logic [9:0]  out_rect_h,
  output logic [7:0]  out_read_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  // Configuration.
  logic [10:0] panel_width_r;
  logic [9:0]  panel_height_r;
  logic [1:0]  rotation_r;
  logic [10:0] pw_eff;
  logic [9:0]  ph_eff;
  logic [15:0] pw16;
  logic [15:0] ph16;

  // Area, stream and dirty state.
  logic [10:0] area_left_r, area_top_r;
  logic [15:0] area_w_r, area_h_r, col_off_r, row_off_r;
  logic [15:0] col_off_nxt, row_off_nxt;
  logic        dirty_valid_r, dirty_valid_nxt;
  logic [9:0]  dirty_left_r, dirty_top_r, dirty_right_r, dirty_bottom_r;
  logic [9:0]  dirty_left_nxt, dirty_top_nxt, dirty_right_nxt, dirty_bottom_nxt;

  // Clearing pass.
  logic                clearing_r;
  logic [STORE_AW-1:0] clr_addr_r;

  // Accept stage.
  op_t         op_in;
  logic        acc;
  logic [15:0] l16, t16, r16, b16;
  logic [15:0] x1, x2, y1, y2, x2s, y2s;
  logic        area_on;
  logic [15:0] lw, lh, sx, sy, col_inc;
  logic        pix_live, pix_in;
  logic [10:0] pw_m1, ph_m1, dx11, dy11;
  logic [7:0]  r8, g8, b8;
  logic [15:0] gray_sum;
  logic        rect_ok;
  logic [15:0] wraw, hraw;

  // Stage 1.
  logic                s1_v_r;
  op_t                 s1_op_r;
  logic                s1_wr_r;
  logic [9:0]          s1_dx_r, s1_dy_r;
  logic [3:0]          s1_lvl_r;
  logic [18:0]         s1_addr_r;
  logic                s1_full_r, s1_rok_r;
  logic [9:0]          s1_x_r, s1_y_r;
  logic [15:0]         s1_wraw_r, s1_hraw_r;
  logic [19:0]         mul_a, mul_b, idx;
  logic [16:0]         sum_w, sum_h;
  logic                s1_rv;
  logic [9:0]          s1_x, s1_y, s1_h;
  logic [10:0]         s1_w;
  logic [STORE_AW-1:0] ram_rd_addr;

  // Stage 2.
  logic                s2_v_r;
  op_t                 s2_op_r;
  logic                s2_wr_r;
  logic [STORE_AW-1:0] s2_addr_r;
  logic                s2_nib_r;
  logic [3:0]          s2_lvl_r;
  logic                s2_rdok_r;
  logic                s2_rv_r;
  logic [9:0]          s2_x_r, s2_y_r, s2_h_r;
  logic [10:0]         s2_w_r;
  logic                fwd_v_r;
  logic [STORE_AW-1:0] fwd_addr_r;
  logic [7:0]          fwd_data_r;
  logic [7:0]          ram_rd_data, cur_byte, merged;
  logic                ram_wr_en;
  logic [STORE_AW-1:0] ram_wr_addr;
  logic [7:0]          ram_wr_data;
  logic                s2_res, adv2, adv1;

  // Output register.
  logic        out_valid_r, out_kind_r, out_rv_r;
  logic [9:0]  out_x_r, out_y_r, out_h_r;
  logic [10:0] out_w_r;
  logic [7:0]  out_data_r;

  assign pw_eff = (panel_width_r > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : panel_width_r;
  assign ph_eff = (panel_height_r > 10'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : panel_height_r;
  assign pw16   = {5'd0, pw_eff};
  assign ph16   = {6'd0, ph_eff};
  assign pw_m1  = pw_eff - 11'd1;
  assign ph_m1  = {1'b0, ph_eff} - 11'd1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r  <= 11'(MAX_WIDTH);
      panel_height_r <= 10'(MAX_HEIGHT);
      rotation_r     <= 2'd0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PANEL_WIDTH:  panel_width_r  <= cfg_data;
        CFG_PANEL_HEIGHT: panel_height_r <= cfg_data[9:0];
        CFG_ROTATION:     rotation_r     <= cfg_data[1:0];
        default:          ;
      endcase
    end
  end

  assign op_in    = op_t'(in_op);
  assign in_ready = adv1 && !clearing_r;
  assign acc      = in_valid && in_ready;

  // Area start: map the source rectangle into panel space.
  assign l16 = {5'd0, in_area_left};
  assign t16 = {5'd0, in_area_top};
  assign r16 = {5'd0, in_area_right};
  assign b16 = {5'd0, in_area_bottom};

  always_comb begin
    case (rotation_r)
      2'd1: begin
        x1 = pw16 - 16'd1 - b16;
        x2 = pw16 - 16'd1 - t16;
        y1 = l16;
        y2 = r16;
      end
      2'd2: begin
        x1 = pw16 - 16'd1 - r16;
        x2 = pw16 - 16'd1 - l16;
        y1 = ph16 - 16'd1 - b16;
        y2 = ph16 - 16'd1 - t16;
      end
      2'd3: begin
        x1 = t16;
        x2 = b16;
        y1 = ph16 - 16'd1 - r16;
        y2 = ph16 - 16'd1 - l16;
      end
      default: begin
        x1 = l16;
        x2 = r16;
        y1 = t16;
        y2 = b16;
      end
    endcase
  end

  assign area_on = (x1 < pw16) && (y1 < ph16);
  assign x2s     = (x2 >= pw16) ? (pw16 - 16'd1) : x2;
  assign y2s     = (y2 >= ph16) ? (ph16 - 16'd1) : y2;

  // Pixel: next raster position of the area and its rotated panel position.
  assign lw       = rotation_r[0] ? ph16 : pw16;
  assign lh       = rotation_r[0] ? pw16 : ph16;
  assign pix_live = (area_w_r != 16'd0) && (row_off_r < area_h_r);
  assign sx       = {5'd0, area_left_r} + col_off_r;
  assign sy       = {5'd0, area_top_r} + row_off_r;
  assign col_inc  = col_off_r + 16'd1;
  assign pix_in   = (sx < lw) && (sy < lh);

  always_comb begin
    case (rotation_r)
      2'd1: begin
        dx11 = pw_m1 - sy[10:0];
        dy11 = sx[10:0];
      end
      2'd2: begin
        dx11 = pw_m1 - sx[10:0];
        dy11 = ph_m1 - sy[10:0];
      end
      2'd3: begin
        dx11 = sy[10:0];
        dy11 = ph_m1 - sx[10:0];
      end
      default: begin
        dx11 = sx[10:0];
        dy11 = sy[10:0];
      end
    endcase
  end

  assign r8       = {in_color[15:11], in_color[15:13]};
  assign g8       = {in_color[10:5], in_color[10:9]};
  assign b8       = {in_color[4:0], in_color[4:2]};
  assign gray_sum = {8'd0, r8} * 16'd77 + {8'd0, g8} * 16'd150 + {8'd0, b8} * 16'd29;

  // Present: raw dirty extent, clamped in stage 1.
  assign rect_ok = dirty_valid_r && ({1'b0, dirty_left_r} < pw_eff) && (dirty_top_r < ph_eff);
  assign wraw    = {6'd0, dirty_right_r} - {6'd0, dirty_left_r} + 16'd1;
  assign hraw    = {6'd0, dirty_bottom_r} - {6'd0, dirty_top_r} + 16'd1;

  always_comb begin
    col_off_nxt      = col_off_r;
    row_off_nxt      = row_off_r;
    dirty_valid_nxt  = dirty_valid_r;
    dirty_left_nxt   = dirty_left_r;
    dirty_top_nxt    = dirty_top_r;
    dirty_right_nxt  = dirty_right_r;
    dirty_bottom_nxt = dirty_bottom_r;
    if (acc) begin
      case (op_in)
        OP_AREA: begin
          col_off_nxt = 16'd0;
          row_off_nxt = 16'd0;
          if (area_on) begin
            dirty_valid_nxt = 1'b1;
            if (!dirty_valid_r) begin
              dirty_left_nxt   = x1[9:0];
              dirty_top_nxt    = y1[9:0];
              dirty_right_nxt  = x2s[9:0];
              dirty_bottom_nxt = y2s[9:0];
            end else begin
              if (x1[9:0] < dirty_left_r)    dirty_left_nxt   = x1[9:0];
              if (y1[9:0] < dirty_top_r)     dirty_top_nxt    = y1[9:0];
              if (x2s[9:0] > dirty_right_r)  dirty_right_nxt  = x2s[9:0];
              if (y2s[9:0] > dirty_bottom_r) dirty_bottom_nxt = y2s[9:0];
            end
          end
        end
        OP_PIXEL: begin
          if (pix_live) begin
            if (col_inc == area_w_r) begin
              col_off_nxt = 16'd0;
              row_off_nxt = row_off_r + 16'd1;
            end else begin
              col_off_nxt = col_inc;
            end
          end
        end
        OP_PRESENT: dirty_valid_nxt = 1'b0;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_left_r    <= '0;
      area_top_r     <= '0;
      area_w_r       <= '0;
      area_h_r       <= '0;
      col_off_r      <= '0;
      row_off_r      <= '0;
      dirty_valid_r  <= 1'b0;
      dirty_left_r   <= '0;
      dirty_top_r    <= '0;
      dirty_right_r  <= '0;
      dirty_bottom_r <= '0;
    end else begin
      if (acc && op_in == OP_AREA) begin
        area_left_r <= in_area_left;
        area_top_r  <= in_area_top;
        area_w_r    <= r16 - l16 + 16'd1;
        area_h_r    <= b16 - t16 + 16'd1;
      end
      col_off_r      <= col_off_nxt;
      row_off_r      <= row_off_nxt;
      dirty_valid_r  <= dirty_valid_nxt;
      dirty_left_r   <= dirty_left_nxt;
      dirty_top_r    <= dirty_top_nxt;
      dirty_right_r  <= dirty_right_nxt;
      dirty_bottom_r <= dirty_bottom_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      if (clr_addr_r == STORE_AW'(STORE_BYTES - 1)) begin
        clearing_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // Stage 1: frame index, RAM read, present clamp.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= acc && (op_in != OP_AREA);
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_op_r   <= op_in;
      s1_wr_r   <= pix_live && pix_in;
      s1_dx_r   <= dx11[9:0];
      s1_dy_r   <= dy11[9:0];
      s1_lvl_r  <= gray_sum[15:12];
      s1_addr_r <= in_read_address;
      s1_full_r <= in_full_refresh;
      s1_rok_r  <= rect_ok;
      s1_x_r    <= dirty_left_r;
      s1_y_r    <= dirty_top_r;
      s1_wraw_r <= wraw;
      s1_hraw_r <= hraw;
    end
  end

  assign mul_a = {10'd0, s1_dy_r};
  assign mul_b = {9'd0, pw_eff};
  assign idx   = mul_a * mul_b + {10'd0, s1_dx_r};
  assign sum_w = {7'd0, s1_x_r} + {1'b0, s1_wraw_r};
  assign sum_h = {7'd0, s1_y_r} + {1'b0, s1_hraw_r};

  always_comb begin
    s1_rv = 1'b0;
    s1_x  = '0;
    s1_y  = '0;
    s1_w  = '0;
    s1_h  = '0;
    if (s1_full_r) begin
      s1_rv = 1'b1;
      s1_w  = pw_eff;
      s1_h  = ph_eff;
    end else if (s1_rok_r) begin
      s1_rv = 1'b1;
      s1_x  = s1_x_r;
      s1_y  = s1_y_r;
      s1_w  = (sum_w > {6'd0, pw_eff}) ? (pw_eff - {1'b0, s1_x_r}) : s1_wraw_r[10:0];
      s1_h  = (sum_h > {7'd0, ph_eff}) ? (ph_eff - s1_y_r) : s1_hraw_r[9:0];
    end
  end

  assign ram_rd_addr = (s1_op_r == OP_READ) ? s1_addr_r[STORE_AW-1:0] : idx[STORE_AW:1];

  // Stage 2: merge nibble with forwarded or stored byte, write back.
  assign s2_res = s2_v_r && (s2_op_r == OP_PRESENT || s2_op_r == OP_READ);
  assign adv2   = !s2_res || !out_valid_r || out_ready;
  assign adv1   = !s1_v_r || adv2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else if (adv2) begin
      s2_v_r  <= s1_v_r;
      fwd_v_r <= ram_wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_op_r    <= s1_op_r;
      s2_wr_r    <= s1_wr_r;
      s2_addr_r  <= ram_rd_addr;
      s2_nib_r   <= idx[0];
      s2_lvl_r   <= s1_lvl_r;
      s2_rdok_r  <= s1_addr_r < 19'(STORE_BYTES);
      s2_rv_r    <= s1_rv;
      s2_x_r     <= s1_x;
      s2_y_r     <= s1_y;
      s2_w_r     <= s1_w;
      s2_h_r     <= s1_h;
      fwd_addr_r <= ram_wr_addr;
      fwd_data_r <= ram_wr_data;
    end
  end

  assign cur_byte = (fwd_v_r && fwd_addr_r == s2_addr_r) ? fwd_data_r : ram_rd_data;
  assign merged   = s2_nib_r ? {cur_byte[7:4], s2_lvl_r} : {s2_lvl_r, cur_byte[3:0]};

  always_comb begin
    if (clearing_r) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr_r;
      ram_wr_data = 8'hFF;
    end else begin
      ram_wr_en   = s2_v_r && (s2_op_r == OP_PIXEL) && s2_wr_r;
      ram_wr_addr = s2_addr_r;
      ram_wr_data = merged;
    end
  end

  rgfw_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (adv2),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_res && adv2) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_res && adv2) begin
      if (s2_op_r == OP_READ) begin
        out_kind_r <= KIND_READ;
        out_rv_r   <= 1'b0;
        out_x_r    <= '0;
        out_y_r    <= '0;
        out_w_r    <= '0;
        out_h_r    <= '0;
        out_data_r <= s2_rdok_r ? cur_byte : 8'd0;
      end else begin
        out_kind_r <= KIND_PRESENT;
        out_rv_r   <= s2_rv_r;
        out_x_r    <= s2_x_r;
        out_y_r    <= s2_y_r;
        out_w_r    <= s2_w_r;
        out_h_r    <= s2_h_r;
        out_data_r <= 8'd0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_rect_valid = out_rv_r;
  assign out_rect_x     = out_x_r;
  assign out_rect_y     = out_y_r;
  assign out_rect_w     = out_w_r;
  assign out_rect_h     = out_h_r;
  assign out_read_data  = out_data_r;

endmodule

@@ hw/rtl/rgfw_checker.sv @@
// ----------------------------------------------------------------------------
// rgfw_checker
// Port-level checks of the rotating gray4 frame writer core, bound into the core module.
// ----------------------------------------------------------------------------
`include "rotating_gray4_frame_writer_core_assert.svh"

module rgfw_checker
  import rgfw_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_op,
  input logic [10:0] in_area_left,
  input logic [10:0] in_area_top,
  input logic [10:0] in_area_right,
  input logic [10:0] in_area_bottom,
  input logic [15:0] in_color,
  input logic        in_full_refresh,
  input logic [18:0] in_read_address,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic        out_rect_valid,
  input logic [9:0]  out_rect_x,
  input logic [9:0]  out_rect_y,
  input logic [10:0] out_rect_w,
  input logic [9:0]  out_rect_h,
  input logic [7:0]  out_read_data,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [10:0] cfg_data
);

  `RGFW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_kind) && $stable(out_read_data) && $stable(out_rect_w))

  `RGFW_ASSERT_IMPL(a_clear_after_reset, $rose(rst_n), !in_ready)

  `RGFW_ASSERT_IMPL(a_read_no_rect, out_valid && out_kind == KIND_READ,
    !out_rect_valid && out_rect_x == 10'd0 && out_rect_y == 10'd0 && out_rect_w == 11'd0 && out_rect_h == 10'd0)

  `RGFW_ASSERT_IMPL(a_present_bounds, out_valid && out_kind == KIND_PRESENT,
    out_read_data == 8'd0 && out_rect_w <= 11'(MAX_WIDTH) && out_rect_h <= 10'(MAX_HEIGHT))

endmodule

bind rotating_gray4_frame_writer_core rgfw_checker u_rgfw_checker (.*);
